// ===== rtl/core/rtsq_pkg.sv =====
// ----------------------------------------------------------------------------
// rtsq_pkg
// Shared types and constants of the ready-time sorted thread queue.
// ----------------------------------------------------------------------------
package rtsq_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int ID_W     = 8;
    localparam int TIME_W   = 32;
    localparam int FUNC_W   = 3;

    // Operation codes carried in the func field.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND  = 3'd0,
        FUNC_INSERT  = 3'd1,
        FUNC_TAKE    = 3'd2,
        FUNC_RESTART = 3'd3,
        FUNC_ADVANCE = 3'd4
    } rtsq_func_t;

    localparam int IN_BITS  = FUNC_W + ID_W + TIME_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + ID_W + CNT_W + 1 + ID_W + 1 + ID_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Input item, first field in the lowest bits.
    typedef struct packed {
        logic [IN_W-IN_BITS-1:0] pad;
        logic [TIME_W-1:0]       ready_time;
        logic [ID_W-1:0]         thread_id;
        logic [FUNC_W-1:0]       func;
    } rtsq_in_t;

    // Result item, first field in the lowest bits.
    typedef struct packed {
        logic [OUT_W-OUT_BITS-1:0] pad;
        logic                      overflow;
        logic [ID_W-1:0]           cursor_id;
        logic                      cursor_valid;
        logic [ID_W-1:0]           front_id;
        logic                      front_valid;
        logic [CNT_W-1:0]          entry_total;
        logic [ID_W-1:0]           taken_id;
        logic                      taken_valid;
    } rtsq_result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic commit;
    } rtsq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } rtsq_stat_t;

endpackage

// ===== rtl/core/rtsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtsq_ctrl
// Controller: takes an item, then commits it once the result register is free.
// ----------------------------------------------------------------------------
module rtsq_ctrl
    import rtsq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  rtsq_stat_t stat,
    output rtsq_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        s_tready   = (state_reg == ST_IDLE);
        cmd.load   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.commit = (state_reg == ST_EXEC) && stat.out_free;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/rtsq_datapath.sv =====
// ----------------------------------------------------------------------------
// rtsq_datapath
// Slot shift register, key compare, cursor tracking and result register.
// ----------------------------------------------------------------------------
module rtsq_datapath
    import rtsq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  rtsq_cmd_t        cmd,
    output rtsq_stat_t       stat,
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    logic [ID_W-1:0]   slot_ids_reg   [DEPTH];
    logic [TIME_W-1:0] slot_times_reg [DEPTH];
    logic [ID_W-1:0]   slot_ids_next  [DEPTH];
    logic [TIME_W-1:0] slot_times_next[DEPTH];

    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [IDX_W-1:0]  cur_pos_reg, cur_pos_next;
    logic              cur_live_reg, cur_live_next;

    logic [FUNC_W-1:0] func_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] time_reg;
    logic [DEPTH-1:0]  hit_reg, hit_next;

    logic              m_tvalid_reg;
    rtsq_result_t      res_reg, res_next;
    rtsq_in_t          in_item;

    logic [DEPTH-1:0]  at_or_after;
    logic [DEPTH-1:0]  before_prev;
    logic              run;
    logic [CNT_W-1:0]  adv_pos;

    assign in_item       = rtsq_in_t'(s_tdata);
    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = res_reg;

    // A slot is a candidate place for the new entry if it is empty, or for a
    // sorted insert if its time is equal or later. The first one wins.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_next[i] = (CNT_W'(i) >= occ_reg)
                       || ((in_item.func == FUNC_INSERT)
                           && (slot_times_reg[i] >= in_item.ready_time));
        end
    end

    always_comb
    begin
        run = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            run            = run | hit_reg[i];
            at_or_after[i] = run;
        end
        before_prev = {at_or_after[DEPTH-2:0], 1'b0};
    end

    assign adv_pos = CNT_W'(cur_pos_reg) + CNT_W'(1);

    always_comb
    begin
        slot_ids_next   = slot_ids_reg;
        slot_times_next = slot_times_reg;
        occ_next        = occ_reg;
        cur_pos_next    = cur_pos_reg;
        cur_live_next   = cur_live_reg;
        res_next        = '0;

        unique case (func_reg)
            FUNC_APPEND, FUNC_INSERT:
            begin
                if (occ_reg == CNT_W'(DEPTH))
                begin
                    res_next.overflow = 1'b1;
                end
                else
                begin
                    if (at_or_after[0])
                    begin
                        slot_ids_next[0]   = id_reg;
                        slot_times_next[0] = time_reg;
                    end
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        if (at_or_after[i] && !before_prev[i])
                        begin
                            slot_ids_next[i]   = id_reg;
                            slot_times_next[i] = time_reg;
                        end
                        else if (at_or_after[i])
                        begin
                            slot_ids_next[i]   = slot_ids_reg[i-1];
                            slot_times_next[i] = slot_times_reg[i-1];
                        end
                    end
                    occ_next = occ_reg + CNT_W'(1);
                    // The cursor always rests below the count, so it moves
                    // back only when the new entry lands at or before it.
                    if (cur_live_reg && at_or_after[cur_pos_reg])
                    begin
                        cur_pos_next = cur_pos_reg + IDX_W'(1);
                    end
                end
            end
            FUNC_TAKE:
            begin
                if (occ_reg != '0)
                begin
                    res_next.taken_valid = 1'b1;
                    res_next.taken_id    = slot_ids_reg[0];
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        slot_ids_next[i]   = slot_ids_reg[i+1];
                        slot_times_next[i] = slot_times_reg[i+1];
                    end
                    occ_next = occ_reg - CNT_W'(1);
                    if (cur_live_reg)
                    begin
                        if (cur_pos_reg == '0)
                        begin
                            cur_live_next = 1'b0;
                        end
                        else
                        begin
                            cur_pos_next = cur_pos_reg - IDX_W'(1);
                        end
                    end
                end
            end
            FUNC_RESTART:
            begin
                cur_pos_next  = '0;
                cur_live_next = (occ_reg != '0);
            end
            FUNC_ADVANCE:
            begin
                if (cur_live_reg)
                begin
                    if (adv_pos >= occ_reg)
                    begin
                        cur_live_next = 1'b0;
                    end
                    else
                    begin
                        cur_pos_next = adv_pos[IDX_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (!cur_live_next)
        begin
            cur_pos_next = '0;
        end

        res_next.entry_total  = occ_next;
        res_next.front_valid  = (occ_next != '0);
        res_next.front_id     = (occ_next != '0) ? slot_ids_next[0] : '0;
        res_next.cursor_valid = cur_live_next;
        res_next.cursor_id    = cur_live_next ? slot_ids_next[cur_pos_next] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            cur_pos_reg  <= '0;
            cur_live_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                occ_reg      <= occ_next;
                cur_pos_reg  <= cur_pos_next;
                cur_live_reg <= cur_live_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_item.func;
            id_reg   <= in_item.thread_id;
            time_reg <= in_item.ready_time;
            hit_reg  <= hit_next;
        end
        if (cmd.commit)
        begin
            slot_ids_reg   <= slot_ids_next;
            slot_times_reg <= slot_times_next;
            res_reg        <= res_next;
        end
    end

endmodule

// ===== rtl/core/ready_time_sorted_thread_queue_unit.sv =====
// ----------------------------------------------------------------------------
// ready_time_sorted_thread_queue_unit
// Bounded queue of thread ids ordered by ready time, with a read cursor.
// ----------------------------------------------------------------------------
// Each item is handled in a compare step and an update step: in the cycle it is
// accepted its ready time is compared against all sixteen stored times at once
// and the hits are registered; then the slot shift register, the count and the
// cursor are updated and the result is written to the output register. No new
// item is accepted until the last one is committed; if the previous result
// has not yet been taken, the update waits in place until the output register
// frees. Tied ready times are inserted ahead of existing entries.
module ready_time_sorted_thread_queue_unit
    import rtsq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // func[2:0], thread_id[10:3], ready_time[42:11], zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // taken_valid[0], taken_id[8:1], entry_total[13:9], front_valid[14],
    // front_id[22:15], cursor_valid[23], cursor_id[31:24], overflow[32], pad
    output logic [OUT_W-1:0] m_tdata
);

    rtsq_cmd_t  cmd;
    rtsq_stat_t stat;

    rtsq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rtsq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // Only one item is in hand at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is being processed");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13:9] <= CNT_W'(DEPTH)))
        else $error("entry count beyond queue depth");

    a_front_matches_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[14] == (m_tdata[13:9] != '0)))
        else $error("front valid disagrees with entry count");

    a_cursor_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[23]) |-> m_tdata[14])
        else $error("cursor valid on an empty queue");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench of the ready-time sorted thread queue unit.
// ----------------------------------------------------------------------------
// Items are sent on the slave stream and results are taken from the master
// stream. A shadow copy of the queue, with its count and read cursor, predicts
// every result at the moment its item is accepted. Results are compared field
// by field in order. Directed tests cover the empty queue, ordering with tied
// and extreme ready times, cursor tracking and overflow. Bursts of random
// operations then run under changing sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import rtsq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes outside the defined operations; the block treats them as no-ops.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 10;

    logic            clk      = 1'b0;
    logic            rst_n    = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata  = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    // Shadow of the queue contents, count and cursor.
    logic [ID_W-1:0]   shadow_ids   [DEPTH];
    logic [TIME_W-1:0] shadow_times [DEPTH];
    int                shadow_count     = 0;
    int                shadow_cursor    = 0;
    logic              shadow_cursor_on = 1'b0;

    rtsq_result_t pending_results[$];

    ready_time_sorted_thread_queue_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // Applies one item to the shadow queue and returns the result it yields.
    function automatic rtsq_result_t shadow_step(input rtsq_in_t op);
        rtsq_result_t res;
        int           pos;
        int           i;
        res = '0;
        case (op.func)
            FUNC_APPEND, FUNC_INSERT:
            begin
                if (shadow_count >= DEPTH)
                begin
                    res.overflow = 1'b1;
                end
                else
                begin
                    pos = shadow_count;
                    // Ties go in front, so the first entry not earlier wins.
                    if (op.func == FUNC_INSERT)
                    begin
                        for (i = shadow_count - 1; i >= 0; i--)
                            if (shadow_times[i] >= op.ready_time)
                                pos = i;
                    end
                    for (i = shadow_count; i > pos; i--)
                    begin
                        shadow_ids[i]   = shadow_ids[i - 1];
                        shadow_times[i] = shadow_times[i - 1];
                    end
                    shadow_ids[pos]   = op.thread_id;
                    shadow_times[pos] = op.ready_time;
                    if (shadow_cursor_on && shadow_cursor >= pos && pos < shadow_count)
                        shadow_cursor++;
                    shadow_count++;
                end
            end
            FUNC_TAKE:
            begin
                if (shadow_count > 0)
                begin
                    res.taken_valid = 1'b1;
                    res.taken_id    = shadow_ids[0];
                    for (i = 1; i < shadow_count; i++)
                    begin
                        shadow_ids[i - 1]   = shadow_ids[i];
                        shadow_times[i - 1] = shadow_times[i];
                    end
                    shadow_count--;
                    if (shadow_cursor_on)
                    begin
                        if (shadow_cursor == 0)
                            shadow_cursor_on = 1'b0;
                        else
                            shadow_cursor--;
                    end
                end
            end
            FUNC_RESTART:
            begin
                shadow_cursor    = 0;
                shadow_cursor_on = (shadow_count > 0);
            end
            FUNC_ADVANCE:
            begin
                if (shadow_cursor_on)
                begin
                    shadow_cursor++;
                    if (shadow_cursor >= shadow_count)
                        shadow_cursor_on = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (!shadow_cursor_on)
            shadow_cursor = 0;

        res.entry_total = CNT_W'(shadow_count);
        if (shadow_count > 0)
        begin
            res.front_valid = 1'b1;
            res.front_id    = shadow_ids[0];
        end
        if (shadow_cursor_on && shadow_cursor < shadow_count)
        begin
            res.cursor_valid = 1'b1;
            res.cursor_id    = shadow_ids[shadow_cursor];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch in %s: got 0x%0h, expected 0x%0h at %0t",
                 what, got, want, $realtime);
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Checks each result against the oldest prediction, then predicts the
    // item accepted at this edge.
    always @(posedge clk)
    begin
        rtsq_result_t got;
        rtsq_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing expected", 32'(got.front_id), '0);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("taken_valid",  32'(got.taken_valid),  32'(want.taken_valid));
                compare_field("taken_id",     32'(got.taken_id),     32'(want.taken_id));
                compare_field("entry_total",  32'(got.entry_total),  32'(want.entry_total));
                compare_field("front_valid",  32'(got.front_valid),  32'(want.front_valid));
                compare_field("front_id",     32'(got.front_id),     32'(want.front_id));
                compare_field("cursor_valid", 32'(got.cursor_valid), 32'(want.cursor_valid));
                compare_field("cursor_id",    32'(got.cursor_id),    32'(want.cursor_id));
                compare_field("overflow",     32'(got.overflow),     32'(want.overflow));
            end
        end
        if (rst_n && s_tvalid && s_tready)
            pending_results.push_back(shadow_step(s_tdata));
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sends one item, with a random gap in front of it, and returns at the
    // edge where it is accepted. The valid is left high for the next item.
    task automatic send_op(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] t);
        rtsq_in_t op;
        op            = '0;
        op.func       = f;
        op.thread_id  = id;
        op.ready_time = t;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= op;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Holds the sender off until every predicted result has been taken.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic logic [TIME_W-1:0] pick_ready_time();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return TIME_W'($urandom_range(0, 7));
            default: return TIME_W'($urandom);
        endcase
    endfunction

    task automatic test_empty_queue();
        send_op(FUNC_TAKE,     8'h00, 32'h0);
        send_op(FUNC_RESTART,  8'hFF, 32'hFFFF_FFFF);
        send_op(FUNC_ADVANCE,  8'h00, 32'h0);
        send_op(FUNC_SPARE_HI, 8'hFF, 32'hFFFF_FFFF);
    endtask

    // Ordering with tied and extreme times, and the cursor following its
    // entry as the queue shifts beneath it.
    task automatic test_order_and_cursor();
        send_op(FUNC_INSERT,  8'h00, 32'hFFFF_FFFF);
        send_op(FUNC_APPEND,  8'hFF, 32'h0);
        send_op(FUNC_RESTART, 8'h00, 32'h0);
        send_op(FUNC_ADVANCE, 8'h00, 32'h0);
        send_op(FUNC_APPEND,  8'h3C, 32'h7);
        send_op(FUNC_INSERT,  8'h5A, 32'hFFFF_FFFF);
        send_op(FUNC_TAKE,    8'h00, 32'h0);
        send_op(FUNC_ADVANCE, 8'h00, 32'h0);
        send_op(FUNC_ADVANCE, 8'h00, 32'h0);
        send_op(FUNC_RESTART, 8'h00, 32'h0);
        send_op(FUNC_TAKE,    8'h00, 32'h0);
    endtask

    task automatic test_full_queue();
        int k;
        wait_all_results();
        for (k = shadow_count; k < DEPTH; k++)
        begin
            if (k % 2)
                send_op(FUNC_INSERT, ID_W'(k * 37 + 1), TIME_W'(k * 32'h1111_1111));
            else
                send_op(FUNC_APPEND, ID_W'(k * 19 + 3), TIME_W'(DEPTH - k));
        end
        send_op(FUNC_APPEND, 8'hEE, 32'h0);
        send_op(FUNC_INSERT, 8'h77, 32'hFFFF_FFFF);
    endtask

    // Bursts of related operations: filling, draining, walking the cursor
    // with the queue changing under it, and plain noise.
    task automatic run_random_ops(input int n_items);
        int                done;
        int                kind;
        int                len;
        int                roll;
        logic [FUNC_W-1:0] f;
        done = 0;
        while (done < n_items)
        begin
            kind = $urandom_range(0, 9);
            len  = (kind <= 4) ? $urandom_range(3, 20) : $urandom_range(2, 12);
            if (kind >= 5 && kind <= 7)
            begin
                send_op(FUNC_RESTART, ID_W'($urandom), pick_ready_time());
                done++;
            end
            repeat (len)
            begin
                roll = $urandom_range(0, 99);
                if (kind <= 2)
                    f = (roll < 70) ? FUNC_INSERT : (roll < 95) ? FUNC_APPEND : FUNC_TAKE;
                else if (kind <= 4)
                    f = (roll < 85) ? FUNC_TAKE : (roll < 95) ? FUNC_ADVANCE : FUNC_INSERT;
                else if (kind <= 7)
                    f = (roll < 60) ? FUNC_ADVANCE : (roll < 80) ? FUNC_INSERT :
                        (roll < 95) ? FUNC_TAKE : FUNC_APPEND;
                else if (kind == 8)
                    f = FUNC_W'($urandom_range(0, 7));
                else
                    f = FUNC_W'($urandom_range(0, 4));
                send_op(f, ID_W'($urandom), pick_ready_time());
                if (f <= FUNC_ADVANCE)
                    done++;
            end
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 0;   recv_stall_pct = 0;
        run_random_ops(212);
        wait_all_results();
        send_idle_pct = 72;  recv_stall_pct = 0;
        run_random_ops(212);
        wait_all_results();
        send_idle_pct = 0;   recv_stall_pct = 72;
        run_random_ops(212);
        wait_all_results();
        send_idle_pct = 36;  recv_stall_pct = 36;
        run_random_ops(214);
        send_op(FUNC_SPARE_LO, ID_W'($urandom), pick_ready_time());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_order_and_cursor();
        test_full_queue();
        test_random_traffic();

        recv_stall_pct = 0;
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== ready_time_sorted_thread_queue_unit.f =====
rtl/core/rtsq_pkg.sv
rtl/core/rtsq_ctrl.sv
rtl/core/rtsq_datapath.sv
rtl/core/ready_time_sorted_thread_queue_unit.sv
tb/tb_top.sv
